// ----- design/text_console_writer_unit_defines.svh -----
// Assertion macros used by the console writer top level.
// Depends on nothing; included by the top level.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Used by the front, back and top level modules; depends on nothing.
package tcw_pkg;
   localparam int Columns = 80;
   localparam int Rows = 25;
   localparam int Cells = Rows * Columns;
   localparam int AddrW = $clog2(Cells);
   localparam int ColW = 7;
   localparam int RowW = 5;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN = 8'd13;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [ColW-1:0] COL_MAX = ColW'(Columns);
   localparam logic [RowW-1:0] ROW_MAX = RowW'(Rows);

   typedef enum logic [1:0] {
      KIND_PUT = 2'd0,
      KIND_SET = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   // Classified operation handed from the front to the back.
   typedef enum logic [2:0] {
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_CHAR,
      OP_SET,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type op;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic read_ok;
   } cmd_type;
endpackage

// ----- design/tcw_front.sv -----
// Front part: accepts items, classifies them and holds them in a short queue.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_kind,
   input logic [7:0] req_char_code,
   input logic [7:0] req_attribute,
   input logic [ColW-1:0] req_col_in,
   input logic [RowW-1:0] req_row_in,
   input logic pop,
   output logic cmd_valid,
   output cmd_type cmd
);
   // Two-entry queue; an item is accepted only while a slot is free.
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in;
   logic push;
   cmd_type c;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   // Classify the item.
   always_comb begin
      c.char_code = req_char_code;
      c.attribute = req_attribute;
      c.col = (req_col_in > COL_MAX) ? COL_MAX : req_col_in;
      c.row = (req_row_in > ROW_MAX) ? ROW_MAX : req_row_in;
      c.read_ok = (req_col_in < COL_MAX) && (req_row_in < ROW_MAX);
      unique case (kind_type'(req_kind))
         KIND_PUT: begin
            if (req_char_code == CH_NEWLINE) c.op = OP_NEWLINE;
            else if (req_char_code == CH_RETURN) c.op = OP_RETURN;
            else if (req_char_code == CH_TAB) c.op = OP_TAB;
            else c.op = OP_CHAR;
         end
         KIND_SET: c.op = OP_SET;
         KIND_CLEAR: c.op = OP_CLEAR;
         default: c.op = OP_READ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = pop ? !rd_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <= c;
   end
endmodule

// ----- design/tcw_back.sv -----
// Back part: executes commands on the cell store and cursor registers.
// Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   input cmd_type cmd,
   output logic pop,
   output logic rsp_valid,
   output logic [ColW-1:0] rsp_cursor_col,
   output logic [RowW-1:0] rsp_cursor_row,
   output logic [15:0] rsp_cell_word,
   output logic rsp_scrolled
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_SCR_RD, ST_SCR_WR, ST_FILL, ST_WRITE, ST_READ
   } state_type;

   logic [15:0] mem [Cells];
   logic [15:0] rdata_ff;
   state_type state_ff;
   cmd_type cmd_ff;
   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic [AddrW-1:0] ptr_ff;
   logic scr_ff;
   logic we, re;
   logic [AddrW-1:0] waddr, raddr;
   logic [15:0] wdata;
   logic [AddrW-1:0] cur_addr;
   logic [RowW-1:0] row_inc;
   logic [ColW+1:0] tab_sum;

   assign cur_addr = AddrW'(row_ff) * AddrW'(Columns) + AddrW'(col_ff);
   assign row_inc = (row_ff >= ROW_MAX) ? ROW_MAX : row_ff + 1'b1;
   assign tab_sum = {2'b0, col_ff} + (ColW+2)'(8);
   assign pop = (state_ff == ST_IDLE) && cmd_valid;

   // Memory port control.
   always_comb begin
      we = 1'b0; re = 1'b0;
      waddr = ptr_ff; raddr = ptr_ff;
      wdata = {cmd_ff.attribute, CH_BLANK};
      unique case (state_ff)
         ST_SCR_RD: re = 1'b1;
         ST_SCR_WR: begin
            we = 1'b1; waddr = ptr_ff - AddrW'(Columns); wdata = rdata_ff;
         end
         ST_FILL: we = 1'b1;
         ST_WRITE: begin
            we = 1'b1; waddr = cur_addr; wdata = {cmd_ff.attribute, cmd_ff.char_code};
         end
         ST_EXEC: begin
            re = (cmd_ff.op == OP_READ) && cmd_ff.read_ok;
            raddr = AddrW'(cmd_ff.row) * AddrW'(Columns) + AddrW'(cmd_ff.col);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   // Sequencer holding cursor and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd;
               scr_ff <= 1'b0;
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
               rsp_cell_word <= '0;
               unique case (cmd_ff.op)
                  OP_NEWLINE: begin col_ff <= '0; row_ff <= row_inc; state_ff <= ST_READ; end
                  OP_RETURN: begin col_ff <= '0; state_ff <= ST_READ; end
                  OP_TAB: begin
                     col_ff <= (tab_sum[ColW+1:3] > (ColW-1)'(Columns/8)) ? COL_MAX
                               : {tab_sum[ColW-1:3], 3'b000};
                     state_ff <= ST_READ;
                  end
                  OP_CHAR: begin
                     logic [RowW-1:0] r;
                     r = (col_ff >= COL_MAX) ? row_inc : row_ff;
                     if (col_ff >= COL_MAX) col_ff <= '0;
                     if (r >= ROW_MAX) begin
                        row_ff <= ROW_MAX - 1'b1;
                        scr_ff <= 1'b1;
                        ptr_ff <= AddrW'(Columns);
                        state_ff <= ST_SCR_RD;
                     end else begin
                        row_ff <= r;
                        state_ff <= ST_WRITE;
                     end
                  end
                  OP_SET: begin
                     col_ff <= cmd_ff.col; row_ff <= cmd_ff.row; state_ff <= ST_READ;
                  end
                  OP_CLEAR: begin
                     col_ff <= '0; row_ff <= '0; ptr_ff <= '0; state_ff <= ST_FILL;
                  end
                  default: state_ff <= ST_READ;
               endcase
            end
            // Copy each cell one row up.
            ST_SCR_RD: state_ff <= ST_SCR_WR;
            ST_SCR_WR: begin
               if (ptr_ff == AddrW'(Cells - 1)) begin
                  ptr_ff <= AddrW'((Rows - 1) * Columns);
                  state_ff <= ST_FILL;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
                  state_ff <= ST_SCR_RD;
               end
            end
            // Blank fill up to the end of the store.
            ST_FILL: begin
               ptr_ff <= ptr_ff + 1'b1;
               if (ptr_ff == AddrW'(Cells - 1))
                  state_ff <= (cmd_ff.op == OP_CHAR) ? ST_WRITE : ST_READ;
            end
            ST_WRITE: begin
               col_ff <= col_ff + 1'b1;
               state_ff <= ST_READ;
            end
            // Issue the result.
            default: begin
               rsp_valid <= 1'b1;
               rsp_cursor_col <= col_ff;
               rsp_cursor_row <= row_ff;
               rsp_cell_word <= (cmd_ff.op == OP_READ && cmd_ff.read_ok) ? rdata_ff : '0;
               rsp_scrolled <= scr_ff;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

// ----- design/text_console_writer_unit.sv -----
// Top level of the text console writer: front queue plus back executor.
// Depends on tcw_pkg, tcw_front, tcw_back and the defines header.
//
// An item is taken when start is high and busy is low; a two-item queue lets
// items arrive while earlier ones execute. The result appears for one cycle on
// rsp_valid and cannot be stalled. Cursor moves, set, and read pass through the
// execute and result states; an ordinary character also passes a write state.
// A scroll walks the cell store, reading and then writing each of 1920 cells
// one row up and blank-filling the 80 bottom cells; a clear blank-fills all
// 2000 cells.
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit import tcw_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_kind,
   input logic [7:0] req_char_code,
   input logic [7:0] req_attribute,
   input logic [ColW-1:0] req_col_in,
   input logic [RowW-1:0] req_row_in,
   output logic rsp_valid,
   output logic [ColW-1:0] rsp_cursor_col,
   output logic [RowW-1:0] rsp_cursor_row,
   output logic [15:0] rsp_cell_word,
   output logic rsp_scrolled
);
   logic pop, cmd_valid;
   cmd_type cmd;

   tcw_front u_front (
      .clock, .reset, .start, .busy, .req_kind, .req_char_code, .req_attribute,
      .req_col_in, .req_row_in, .pop, .cmd_valid, .cmd
   );

   tcw_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .pop, .rsp_valid, .rsp_cursor_col,
      .rsp_cursor_row, .rsp_cell_word, .rsp_scrolled
   );

   `TCW_ASSERT_IMP(a_col_range, rsp_valid, rsp_cursor_col <= COL_MAX, "column out of range")
   `TCW_ASSERT_IMP(a_row_range, rsp_valid, rsp_cursor_row <= ROW_MAX, "row out of range")
   `TCW_ASSERT_IMP(a_scroll_row, rsp_valid && rsp_scrolled,
      rsp_cursor_row == ROW_MAX - 1'b1, "scroll left wrong row")
   `TCW_ASSERT_NEXT(a_pop_valid, pop, !pop, "back took two commands in a row")
endmodule

// ----- test/text_console_writer_unit_tb.sv -----
// Self-checking testbench for the text console writer: puts, cursor sets,
// clears and cell reads checked against an in-bench cell store and cursor.
// Depends on tcw_pkg and the text_console_writer_unit design.
module text_console_writer_unit_tb;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type kind;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic [ColW-1:0] col_in;
      logic [RowW-1:0] row_in;
   } console_item_type;

   typedef struct {
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic [15:0] word;
      logic scrolled;
   } console_status_type;

   localparam int IdleLimit = 30000;
   localparam int RandomItems = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_attribute = '0;
   logic [ColW-1:0] req_col_in = '0;
   logic [RowW-1:0] req_row_in = '0;
   logic rsp_valid;
   logic [ColW-1:0] rsp_cursor_col;
   logic [RowW-1:0] rsp_cursor_row;
   logic [15:0] rsp_cell_word;
   logic rsp_scrolled;

   console_item_type item_queue[$];
   console_status_type status_queue[$];
   logic [15:0] shadow_cells[Cells];
   int shadow_col = 0;
   int shadow_row = 0;
   int sent_count = 0;
   int taken_count = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   bit stimulus_done = 0;
   bit hold_for_drain = 0;

   text_console_writer_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_char_code(req_char_code),
      .req_attribute(req_attribute), .req_col_in(req_col_in),
      .req_row_in(req_row_in), .rsp_valid(rsp_valid),
      .rsp_cursor_col(rsp_cursor_col), .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_word(rsp_cell_word), .rsp_scrolled(rsp_scrolled)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one item to the shadow console and return the status it causes.
   function automatic console_status_type console_apply(console_item_type it);
      console_status_type st;
      int tab_col;
      st.word = '0;
      st.scrolled = 1'b0;
      case (it.kind)
         KIND_PUT: begin
            if (it.char_code == CH_NEWLINE) begin
               shadow_col = 0;
               shadow_row = (shadow_row >= Rows) ? Rows : shadow_row + 1;
            end else if (it.char_code == CH_RETURN) begin
               shadow_col = 0;
            end else if (it.char_code == CH_TAB) begin
               tab_col = (shadow_col + 8) & ~7;
               shadow_col = (tab_col > Columns) ? Columns : tab_col;
            end else begin
               if (shadow_col >= Columns) begin
                  shadow_col = 0;
                  shadow_row = (shadow_row >= Rows) ? Rows : shadow_row + 1;
               end
               // Scroll up one row and blank the bottom row.
               if (shadow_row >= Rows) begin
                  for (int i = 0; i < Cells - Columns; i++)
                     shadow_cells[i] = shadow_cells[i + Columns];
                  for (int i = Cells - Columns; i < Cells; i++)
                     shadow_cells[i] = {it.attribute, CH_BLANK};
                  shadow_row = Rows - 1;
                  st.scrolled = 1'b1;
               end
               shadow_cells[shadow_row * Columns + shadow_col] = {it.attribute, it.char_code};
               shadow_col++;
            end
         end
         KIND_SET: begin
            shadow_col = (it.col_in > Columns) ? Columns : it.col_in;
            shadow_row = (it.row_in > Rows) ? Rows : it.row_in;
         end
         KIND_CLEAR: begin
            for (int i = 0; i < Cells; i++)
               shadow_cells[i] = {it.attribute, CH_BLANK};
            shadow_col = 0;
            shadow_row = 0;
         end
         default: begin
            if (it.col_in < Columns && it.row_in < Rows)
               st.word = shadow_cells[it.row_in * Columns + it.col_in];
         end
      endcase
      st.col = ColW'(shadow_col);
      st.row = RowW'(shadow_row);
      return st;
   endfunction

   function automatic console_item_type make_item(kind_type k, int ch, int attr, int c, int r);
      console_item_type it;
      it.kind = k;
      it.char_code = ch[7:0];
      it.attribute = attr[7:0];
      it.col_in = c[ColW-1:0];
      it.row_in = r[RowW-1:0];
      return it;
   endfunction

   // Random item; the store is fully written by the opening clear.
   function automatic console_item_type random_item();
      console_item_type it;
      int pick;
      int sel;
      it = make_item(KIND_PUT, $urandom_range(32, 126), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (pick < 60) begin
         if (sel < 15) it.char_code = $urandom_range(0, 255);
         else if (sel < 22) it.char_code = CH_NEWLINE;
         else if (sel < 26) it.char_code = CH_RETURN;
         else if (sel < 30) it.char_code = CH_TAB;
      end else if (pick < 68) begin
         it.kind = KIND_SET;
         if (sel < 90) begin
            it.col_in = $urandom_range(0, Columns - 1);
            it.row_in = $urandom_range(0, Rows - 1);
         end
      end else if (pick < 70) begin
         it.kind = KIND_CLEAR;
      end else begin
         it.kind = KIND_READ;
         if (sel < 90) begin
            it.col_in = $urandom_range(0, Columns - 1);
            it.row_in = $urandom_range(0, Rows - 1);
         end
      end
      return it;
   endfunction

   // Stimulus: directed corners, then random items.
   initial begin
      item_queue.push_back(make_item(KIND_CLEAR, 0, 8'h07, 0, 0));
      item_queue.push_back(make_item(KIND_READ, 0, 0, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, 8'h00, 8'h00, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, 8'hFF, 8'hFF, 127, 31));
      item_queue.push_back(make_item(KIND_PUT, CH_TAB, 8'h1E, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, CH_RETURN, 8'h1E, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, CH_NEWLINE, 8'h1E, 0, 0));
      item_queue.push_back(make_item(KIND_READ, 0, 0, 1, 0));
      // Last cell, then a wrap that forces a scroll.
      item_queue.push_back(make_item(KIND_SET, 0, 0, Columns - 1, Rows - 1));
      item_queue.push_back(make_item(KIND_PUT, 8'h41, 8'h4F, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, 8'h42, 8'hA5, 0, 0));
      item_queue.push_back(make_item(KIND_READ, 0, 0, Columns - 1, Rows - 2));
      item_queue.push_back(make_item(KIND_READ, 0, 0, 5, Rows - 1));
      // Tab saturates at the width.
      item_queue.push_back(make_item(KIND_SET, 0, 0, 76, 3));
      item_queue.push_back(make_item(KIND_PUT, CH_TAB, 0, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, CH_TAB, 0, 0, 0));
      // Out-of-range set saturates; newline saturates the row; then a put.
      item_queue.push_back(make_item(KIND_SET, 0, 0, 127, 31));
      item_queue.push_back(make_item(KIND_PUT, CH_NEWLINE, 0, 0, 0));
      item_queue.push_back(make_item(KIND_PUT, 8'h7E, 8'h5A, 0, 0));
      // Reads outside the store answer zero.
      item_queue.push_back(make_item(KIND_READ, 0, 0, 127, 31));
      item_queue.push_back(make_item(KIND_READ, 0, 0, Columns, 0));
      item_queue.push_back(make_item(KIND_READ, 0, 0, 0, Rows));
      item_queue.push_back(make_item(KIND_CLEAR, 0, 8'hFF, 0, 0));
      item_queue.push_back(make_item(KIND_READ, 0, 0, Columns - 1, Rows - 1));
      for (int i = 0; i < RandomItems; i++)
         item_queue.push_back(random_item());
      stimulus_done = 1;
   end

   // Reset and end of run; the end check looks at settled values on each rising edge.
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      do @(posedge clock);
      while (!(stimulus_done && item_queue.size() == 0 && sent_count == taken_count &&
               status_queue.size() == 0));
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && status_queue.size() == 0) begin
         $display("** text_console_writer_unit: PASSED **");
      end else begin
         $display("** text_console_writer_unit: FAILED **");
      end
      $finish;
   end

   // Driver: bursts with random gaps, one drain pause midway.
   always @(negedge clock) begin
      if (!reset && !(start && sent_count != taken_count)) begin
         if (hold_for_drain) begin
            if (status_queue.size() == 0) hold_for_drain <= 0;
            start <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (item_queue.size() > 0) begin
            console_item_type it;
            it = item_queue.pop_front();
            req_kind <= it.kind;
            req_char_code <= it.char_code;
            req_attribute <= it.attribute;
            req_col_in <= it.col_in;
            req_row_in <= it.row_in;
            start <= 1'b1;
            sent_count <= sent_count + 1;
            if (sent_count == 600) hold_for_drain <= 1;
            else if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 12);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on acceptance, compare each result with the oldest status.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (start && !busy) begin
            status_queue.push_back(console_apply(make_item(kind_type'(req_kind),
               req_char_code, req_attribute, req_col_in, req_row_in)));
            taken_count <= taken_count + 1;
         end
         if (rsp_valid) begin
            if (status_queue.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) $display("unexpected result with nothing pending");
            end else begin
               console_status_type st;
               st = status_queue.pop_front();
               if (rsp_cursor_col !== st.col || rsp_cursor_row !== st.row ||
                   rsp_cell_word !== st.word || rsp_scrolled !== st.scrolled) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: expected col %0d row %0d word %h scr %b, got %0d %0d %h %b",
                        st.col, st.row, st.word, st.scrolled, rsp_cursor_col,
                        rsp_cursor_row, rsp_cell_word, rsp_scrolled);
               end
            end
         end
         if (idle_cycles >= IdleLimit) begin
            $display("** text_console_writer_unit: FAILED **");
            $finish;
         end
      end
   end
endmodule
